FILE: rtl/core/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg: shared types and constants of the replay-macro stream parser
// Parse phases, result kinds, magic bytes and the queue entry that travels
// from the byte parser to the result emitter.
// ----------------------------------------------------------------------------
package rmsp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_EVENT   = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_MAGIC   = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_LONG    = 3'd4;
    localparam logic [2:0] KIND_TRUNC   = 3'd5;

    // Magic bytes and the only accepted format version
    localparam logic [7:0]  MAGIC_G     = 8'h47;
    localparam logic [7:0]  MAGIC_D     = 8'h44;
    localparam logic [7:0]  MAGIC_R     = 8'h52;
    localparam logic [63:0] FMT_VERSION = 64'd2;

    // Varint: continuation flag position and last allowed group index
    localparam int          VARINT_CONT_BIT  = 7;
    localparam logic [3:0]  VARINT_LAST_GRP  = 4'd9;

    // Fixed run lengths of the header
    localparam logic [63:0] DURATION_BYTES = 64'd4;
    localparam logic [63:0] FPS_BYTES      = 64'd8;
    localparam logic [63:0] SEED_VARINTS   = 64'd2;
    localparam logic [63:0] FLAG_BYTES     = 64'd2;
    localparam logic [63:0] BOTVER_VARINTS = 64'd2;

    // Raw button codes and mapped button values
    localparam logic [1:0] RAW_LEFT  = 2'd2;
    localparam logic [1:0] RAW_RIGHT = 2'd3;
    localparam logic [1:0] RAW_DEFAULT = 2'd1;
    localparam logic [1:0] BTN_JUMP  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    // Queue between parser and emitter
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [4:0] {
        PH_MAG_G        = 5'd0,
        PH_MAG_D        = 5'd1,
        PH_MAG_R        = 5'd2,
        PH_VERSION      = 5'd3,
        PH_EXT_LEN      = 5'd4,
        PH_EXT_SKIP     = 5'd5,
        PH_AUTH_LEN     = 5'd6,
        PH_AUTH_SKIP    = 5'd7,
        PH_DESC_LEN     = 5'd8,
        PH_DESC_SKIP    = 5'd9,
        PH_DURATION     = 5'd10,
        PH_GAMEVER      = 5'd11,
        PH_FPS          = 5'd12,
        PH_SEED_COINS   = 5'd13,
        PH_FLAGS        = 5'd14,
        PH_BOT_LEN      = 5'd15,
        PH_BOT_SKIP     = 5'd16,
        PH_BOTVER_LEVEL = 5'd17,
        PH_LNAME_LEN    = 5'd18,
        PH_LNAME_SKIP   = 5'd19,
        PH_XDATA_LEN    = 5'd20,
        PH_XDATA_SKIP   = 5'd21,
        PH_DEATH_COUNT  = 5'd22,
        PH_DEATHS       = 5'd23,
        PH_TOTAL        = 5'd24,
        PH_P1COUNT      = 5'd25,
        PH_INPUT        = 5'd26,
        PH_PHYS_LEN     = 5'd27,
        PH_PHYS_SKIP    = 5'd28,
        PH_DONE         = 5'd29
    } phase_t;

    // One parsed byte: an optional event and an optional final status
    typedef struct packed {
        logic        has_event;
        logic        clear_sum;
        logic [63:0] delta;
        logic [1:0]  button;
        logic        pressed;
        logic        second_player;
        logic        has_status;
        logic [2:0]  kind;
        logic [63:0] fps_bits;
    } q_entry_t;

endpackage

FILE: rtl/core/replay_macro_stream_parser.sv
// ----------------------------------------------------------------------------
// replay_macro_stream_parser: streaming parser for replay-macro files
// Feed the file one byte per transaction on the s_ channel, with
// s_end_of_file set on its final byte. The m_ channel returns one event
// transaction per input record (kind 0, accumulated frame, button, press,
// player) and one status transaction (m_last set) with the final byte:
// done with the fps word, or an error kind. Events of a file that ends in
// an error status must be discarded by the receiver.
// Throughput: one byte per cycle while the queue has room. A byte that
// yields a result passes through the queue, then the output register, to
// m_; a final byte that also closes an event gives the event, then the
// status, as two transactions from one queue entry.
// A four-entry queue parts the byte parser from the emitter: when the
// receiver stalls, bytes keep being taken until the queue is full, then
// s_ready drops. Bytes that produce no result never enter the queue.
// Reset (aresetn low, synchronous) empties the queue and the output stage
// and puts the parser at the first magic byte; the same parser state is
// restored after every final byte.
// ----------------------------------------------------------------------------
module replay_macro_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [63:0] m_frame,
    output logic [1:0]  m_button,
    output logic        m_pressed,
    output logic        m_second_player,
    output logic [63:0] m_fps_bits,
    output logic        m_last
);
    import rmsp_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_wdata;
    q_entry_t q_head;

    // Byte parser
    rmsp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .s_end_of_file (s_end_of_file),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    // Queue between parser and emitter
    rmsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Result emitter
    rmsp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_frame         (m_frame),
        .m_button        (m_button),
        .m_pressed       (m_pressed),
        .m_second_player (m_second_player),
        .m_fps_bits      (m_fps_bits),
        .m_last          (m_last)
    );

endmodule

FILE: rtl/core/rmsp_front.sv
// ----------------------------------------------------------------------------
// rmsp_front: byte parser
// Walks the file header one byte per cycle while the queue has room, decodes
// varints, classifies input records, queues event deltas and final status.
// ----------------------------------------------------------------------------
module rmsp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_data_byte,
    input  logic               s_end_of_file,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               q_full,
    output logic               q_push,
    output rmsp_pkg::q_entry_t q_wdata
);
    import rmsp_pkg::*;

    // Parser state
    phase_t      phase_reg,    phase_next;
    logic [63:0] acc_reg,      acc_next;
    logic [3:0]  grp_reg,      grp_next;
    logic [63:0] skip_reg,     skip_next;
    logic        has_ext_reg,  has_ext_next;
    logic        platform_reg, platform_next;
    logic [63:0] deaths_reg,   deaths_next;
    logic [63:0] total_reg,    total_next;
    logic [63:0] left_reg,     left_next;
    logic [63:0] fps_reg,      fps_next;
    logic        in2_reg,      in2_next;
    logic        err_reg,      err_next;
    logic [2:0]  err_kind_reg, err_kind_next;
    logic        clear_reg,    clear_next;

    // Shared decode
    logic        take;
    logic        cont;
    logic [5:0]  shamt;
    logic [63:0] acc_new;
    logic [63:0] skip_dec;
    logic        skip_last;
    logic [63:0] deaths_dec;
    logic [63:0] total_sub;
    logic [2:0]  fps_idx;
    logic [63:0] ev_delta;
    logic [1:0]  ev_raw;
    logic [1:0]  ev_button;
    logic        ev_now;

    // next-input helper
    logic [63:0] ni_left_in;
    logic        ni_in2_in;
    logic [63:0] ni_total_in;
    logic        ni_switch;
    logic [63:0] ni_left_out;
    phase_t      ni_phase;

    // Results of the byte before end-of-file clearing
    logic        fail;
    logic [2:0]  fail_kind;
    phase_t      phase_parsed;
    logic [63:0] fps_parsed;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign cont    = s_data_byte[VARINT_CONT_BIT];

    // Varint group placement
    assign shamt   = {2'b00, grp_reg} * 6'd7;
    assign acc_new = acc_reg | ({57'd0, s_data_byte[6:0]} << shamt);

    assign skip_dec   = skip_reg - 64'd1;
    assign skip_last  = (skip_reg == 64'd1);
    assign deaths_dec = deaths_reg - 64'd1;
    assign total_sub  = (total_reg > acc_new) ? (total_reg - acc_new) : 64'd0;
    assign fps_idx    = 3'(4'd8 - skip_reg[3:0]);

    // Input record decode
    assign ev_delta = platform_reg ? {3'b000, acc_new[63:3]} : {1'b0, acc_new[63:1]};
    assign ev_raw   = platform_reg ? acc_new[2:1] : RAW_DEFAULT;

    always_comb begin
        case (ev_raw)
            RAW_LEFT:  ev_button = BTN_LEFT;
            RAW_RIGHT: ev_button = BTN_RIGHT;
            default:   ev_button = BTN_JUMP;
        endcase
    end

    assign ev_now = take && !err_reg && (phase_reg == PH_INPUT) && !cont;

    // Move to the next input record, switching to player two when needed
    always_comb begin
        ni_left_in  = left_reg;
        ni_in2_in   = in2_reg;
        ni_total_in = total_reg;
        if (phase_reg == PH_P1COUNT) begin
            ni_left_in  = acc_new;
            ni_in2_in   = 1'b0;
            ni_total_in = total_sub;
        end else if (phase_reg == PH_INPUT) begin
            ni_left_in  = left_reg - 64'd1;
        end
        ni_switch   = (ni_left_in == 64'd0) && !ni_in2_in;
        ni_left_out = ni_switch ? ni_total_in : ni_left_in;
        ni_phase    = (ni_left_out == 64'd0) ? PH_DONE : PH_INPUT;
    end

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        grp_next      = grp_reg;
        skip_next     = skip_reg;
        has_ext_next  = has_ext_reg;
        platform_next = platform_reg;
        deaths_next   = deaths_reg;
        total_next    = total_reg;
        left_next     = left_reg;
        fps_next      = fps_reg;
        in2_next      = in2_reg;
        err_next      = err_reg;
        err_kind_next = err_kind_reg;
        clear_next    = clear_reg;
        fail          = 1'b0;
        fail_kind     = KIND_MAGIC;

        if (take && !err_reg) begin
            unique case (phase_reg) inside
                PH_MAG_G: begin
                    if (s_data_byte != MAGIC_G) fail = 1'b1;
                    else phase_next = PH_MAG_D;
                end
                PH_MAG_D: begin
                    if (s_data_byte != MAGIC_D) fail = 1'b1;
                    else phase_next = PH_MAG_R;
                end
                PH_MAG_R: begin
                    if (s_data_byte != MAGIC_R) fail = 1'b1;
                    else phase_next = PH_VERSION;
                end
                PH_EXT_SKIP, PH_AUTH_SKIP, PH_DESC_SKIP, PH_DURATION,
                PH_BOT_SKIP, PH_LNAME_SKIP, PH_XDATA_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_last) phase_next = phase_t'(phase_reg + 5'd1);
                end
                PH_PHYS_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_last) begin
                        phase_next = ni_phase;
                        left_next  = ni_left_out;
                        in2_next   = ni_switch || ni_in2_in;
                        clear_next = clear_reg || ni_switch;
                    end
                end
                PH_FPS: begin
                    fps_next[{fps_idx, 3'b000} +: 8] = s_data_byte;
                    skip_next = skip_dec;
                    if (skip_last) phase_next = PH_SEED_COINS;
                end
                PH_FLAGS: begin
                    if (skip_last) platform_next = (s_data_byte != 8'd0);
                    skip_next = skip_dec;
                    if (skip_last) phase_next = PH_BOT_LEN;
                end
                PH_DONE: begin
                end
                default: begin
                    // varint-coded fields
                    if (cont) begin
                        acc_next = acc_new;
                        grp_next = grp_reg + 4'd1;
                        if (grp_reg == VARINT_LAST_GRP) begin
                            fail      = 1'b1;
                            fail_kind = KIND_LONG;
                        end
                    end else begin
                        acc_next = 64'd0;
                        grp_next = 4'd0;
                        unique case (phase_reg)
                            PH_VERSION: begin
                                if (acc_new != FMT_VERSION) begin
                                    fail      = 1'b1;
                                    fail_kind = KIND_VERSION;
                                end else begin
                                    phase_next = PH_EXT_LEN;
                                end
                            end
                            PH_EXT_LEN: begin
                                has_ext_next = (acc_new != 64'd0);
                                skip_next    = acc_new;
                                phase_next   = (acc_new == 64'd0) ? PH_AUTH_LEN : PH_EXT_SKIP;
                            end
                            PH_AUTH_LEN: begin
                                skip_next  = acc_new;
                                phase_next = (acc_new == 64'd0) ? PH_DESC_LEN : PH_AUTH_SKIP;
                            end
                            PH_DESC_LEN: begin
                                skip_next  = acc_new;
                                phase_next = (acc_new == 64'd0) ? PH_DURATION : PH_DESC_SKIP;
                            end
                            PH_GAMEVER: phase_next = PH_FPS;
                            PH_SEED_COINS: begin
                                skip_next = skip_dec;
                                if (skip_last) phase_next = PH_FLAGS;
                            end
                            PH_BOT_LEN: begin
                                skip_next  = acc_new;
                                phase_next = (acc_new == 64'd0) ? PH_BOTVER_LEVEL : PH_BOT_SKIP;
                            end
                            PH_BOTVER_LEVEL: begin
                                skip_next = skip_dec;
                                if (skip_last) phase_next = PH_LNAME_LEN;
                            end
                            PH_LNAME_LEN: begin
                                skip_next  = acc_new;
                                phase_next = (acc_new == 64'd0) ? PH_XDATA_LEN : PH_LNAME_SKIP;
                            end
                            PH_XDATA_LEN: begin
                                skip_next  = acc_new;
                                phase_next = (acc_new == 64'd0) ? PH_DEATH_COUNT
                                                                : PH_XDATA_SKIP;
                            end
                            PH_DEATH_COUNT: begin
                                deaths_next = acc_new;
                                phase_next  = (acc_new == 64'd0) ? PH_TOTAL : PH_DEATHS;
                            end
                            PH_DEATHS: begin
                                deaths_next = deaths_dec;
                                if (deaths_dec == 64'd0) phase_next = PH_TOTAL;
                            end
                            PH_TOTAL: begin
                                total_next = acc_new;
                                phase_next = PH_P1COUNT;
                            end
                            PH_P1COUNT: begin
                                total_next = total_sub;
                                left_next  = ni_left_out;
                                in2_next   = ni_switch;
                                clear_next = 1'b1;
                                phase_next = ni_phase;
                            end
                            PH_INPUT: begin
                                // the event consumes a pending sum clear
                                if (has_ext_reg) begin
                                    left_next  = left_reg - 64'd1;
                                    clear_next = 1'b0;
                                    phase_next = PH_PHYS_LEN;
                                end else begin
                                    left_next  = ni_left_out;
                                    in2_next   = ni_switch || ni_in2_in;
                                    clear_next = ni_switch;
                                    phase_next = ni_phase;
                                end
                            end
                            PH_PHYS_LEN: begin
                                if (acc_new == 64'd0) begin
                                    left_next  = ni_left_out;
                                    in2_next   = ni_switch || ni_in2_in;
                                    clear_next = clear_reg || ni_switch;
                                    phase_next = ni_phase;
                                end else begin
                                    skip_next  = acc_new;
                                    phase_next = PH_PHYS_SKIP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase

            // Preset the run length on entry to a fixed-length field
            if (!fail && (phase_next != phase_reg)) begin
                unique case (phase_next)
                    PH_DURATION:     skip_next = DURATION_BYTES;
                    PH_FPS:          skip_next = FPS_BYTES;
                    PH_SEED_COINS:   skip_next = SEED_VARINTS;
                    PH_FLAGS:        skip_next = FLAG_BYTES;
                    PH_BOTVER_LEVEL: skip_next = BOTVER_VARINTS;
                    default: begin
                    end
                endcase
            end

            if (fail) begin
                err_next      = 1'b1;
                err_kind_next = fail_kind;
            end
        end

        phase_parsed = phase_next;
        fps_parsed   = fps_next;

        // End of file: back to the reset state for the next file
        if (take && s_end_of_file) begin
            phase_next    = PH_MAG_G;
            acc_next      = 64'd0;
            grp_next      = 4'd0;
            skip_next     = 64'd0;
            has_ext_next  = 1'b0;
            platform_next = 1'b0;
            deaths_next   = 64'd0;
            total_next    = 64'd0;
            left_next     = 64'd0;
            fps_next      = 64'd0;
            in2_next      = 1'b0;
            err_next      = 1'b0;
            err_kind_next = KIND_MAGIC;
            clear_next    = 1'b0;
        end
    end

    // Queue entry for this byte
    always_comb begin
        q_push                = take && (ev_now || s_end_of_file);
        q_wdata               = '0;
        q_wdata.has_event     = ev_now;
        q_wdata.clear_sum     = clear_reg;
        q_wdata.delta         = ev_delta;
        q_wdata.button        = ev_button;
        q_wdata.pressed       = acc_new[0];
        q_wdata.second_player = in2_reg;
        q_wdata.has_status    = s_end_of_file;
        if (err_reg) begin
            q_wdata.kind = err_kind_reg;
        end else if (fail) begin
            q_wdata.kind = fail_kind;
        end else if (phase_parsed == PH_DONE) begin
            q_wdata.kind     = KIND_OK;
            q_wdata.fps_bits = fps_parsed;
        end else begin
            q_wdata.kind = KIND_TRUNC;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MAG_G;
            acc_reg      <= 64'd0;
            grp_reg      <= 4'd0;
            skip_reg     <= 64'd0;
            has_ext_reg  <= 1'b0;
            platform_reg <= 1'b0;
            deaths_reg   <= 64'd0;
            total_reg    <= 64'd0;
            left_reg     <= 64'd0;
            fps_reg      <= 64'd0;
            in2_reg      <= 1'b0;
            err_reg      <= 1'b0;
            err_kind_reg <= KIND_MAGIC;
            clear_reg    <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            grp_reg      <= grp_next;
            skip_reg     <= skip_next;
            has_ext_reg  <= has_ext_next;
            platform_reg <= platform_next;
            deaths_reg   <= deaths_next;
            total_reg    <= total_next;
            left_reg     <= left_next;
            fps_reg      <= fps_next;
            in2_reg      <= in2_next;
            err_reg      <= err_next;
            err_kind_reg <= err_kind_next;
            clear_reg    <= clear_next;
        end
    end

endmodule

FILE: rtl/core/rmsp_queue.sv
// ----------------------------------------------------------------------------
// rmsp_queue: short queue of parsed bytes
// Register-based FIFO between the byte parser and the result emitter.
// ----------------------------------------------------------------------------
module rmsp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rmsp_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output rmsp_pkg::q_entry_t head
);
    import rmsp_pkg::*;

    q_entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                              : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                              : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        else if (!push && pop) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) entries_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: rtl/core/rmsp_back.sv
// ----------------------------------------------------------------------------
// rmsp_back: result emitter
// Accumulates the per-player frame sum and drives the registered result
// channel: an event, then the status where a queue entry carries both.
// ----------------------------------------------------------------------------
module rmsp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  rmsp_pkg::q_entry_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [63:0]        m_frame,
    output logic [1:0]         m_button,
    output logic               m_pressed,
    output logic               m_second_player,
    output logic [63:0]        m_fps_bits,
    output logic               m_last
);
    import rmsp_pkg::*;

    logic        valid_reg,   valid_next;
    logic        ev_sent_reg, ev_sent_next;
    logic [63:0] sum_reg,     sum_next;
    logic [2:0]  kind_reg,    kind_next;
    logic [63:0] frame_reg,   frame_next;
    logic [1:0]  button_reg,  button_next;
    logic        pressed_reg, pressed_next;
    logic        second_reg,  second_next;
    logic [63:0] fps_reg,     fps_next;
    logic        last_reg,    last_next;

    logic        load;
    logic [63:0] frame_sum;

    assign load      = !valid_reg || m_ready;
    assign frame_sum = (q_head.clear_sum ? 64'd0 : sum_reg) + q_head.delta;

    // Output stage loading
    always_comb begin
        valid_next   = valid_reg;
        ev_sent_next = ev_sent_reg;
        sum_next     = sum_reg;
        kind_next    = kind_reg;
        frame_next   = frame_reg;
        button_next  = button_reg;
        pressed_next = pressed_reg;
        second_next  = second_reg;
        fps_next     = fps_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        if (load) begin
            valid_next = q_valid;
            if (q_valid) begin
                if (q_head.has_event && !ev_sent_reg) begin
                    kind_next    = KIND_EVENT;
                    frame_next   = frame_sum;
                    sum_next     = frame_sum;
                    button_next  = q_head.button;
                    pressed_next = q_head.pressed;
                    second_next  = q_head.second_player;
                    fps_next     = 64'd0;
                    last_next    = 1'b0;
                    if (q_head.has_status) ev_sent_next = 1'b1;
                    else q_pop = 1'b1;
                end else begin
                    kind_next    = q_head.kind;
                    frame_next   = 64'd0;
                    button_next  = BTN_JUMP;
                    pressed_next = 1'b0;
                    second_next  = 1'b0;
                    fps_next     = q_head.fps_bits;
                    last_next    = 1'b1;
                    ev_sent_next = 1'b0;
                    q_pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            ev_sent_reg <= 1'b0;
            sum_reg     <= 64'd0;
        end else begin
            valid_reg   <= valid_next;
            ev_sent_reg <= ev_sent_next;
            sum_reg     <= sum_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        frame_reg   <= frame_next;
        button_reg  <= button_next;
        pressed_reg <= pressed_next;
        second_reg  <= second_next;
        fps_reg     <= fps_next;
        last_reg    <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_frame         = frame_reg;
    assign m_button        = button_reg;
    assign m_pressed       = pressed_reg;
    assign m_second_player = second_reg;
    assign m_fps_bits      = fps_reg;
    assign m_last          = last_reg;

endmodule

FILE: tb/replay_macro_stream_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_macro_stream_parser_test: self-checking bench for the macro parser
// Streams replay-macro files into the parser one byte per transaction. Most
// files are well formed with random content. The rest carry a bad magic, a
// bad version, an overlong varint, an oversized skip length or an early
// end. A predictor in the scoreboard works out the events and the final
// status of every byte, and each m_ transaction is checked field by field.
// ----------------------------------------------------------------------------
module replay_macro_stream_parser_test;

    import rmsp_pkg::*;

    localparam int unsigned ITEM_TARGET    = 1450;
    localparam int unsigned RX_HOLD_CYCLES = 120;
    localparam int unsigned SETTLE_CYCLES  = 20;

    // One m_ transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] frame;
        logic [1:0]  button;
        logic        pressed;
        logic        second_player;
        logic [63:0] fps_bits;
        logic        last;
    } result_t;

    // Ways a generated file is spoilt
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_LONG,
        FLAW_CUT,
        FLAW_HUGE_SKIP
    } flaw_t;

    // ------------------------------------------------------------------------
    // Scoreboard: file parser prediction and the queue of expected results
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        phase_t      phase;
        bit          err_seen;
        logic [2:0]  err_kind;
        logic [63:0] vacc;
        int unsigned vgroups;
        logic [63:0] run_left;
        bit          ext_on;
        bit          platformer;
        logic [63:0] deaths_left;
        logic [63:0] p2_count;
        logic [63:0] inputs_left;
        logic [63:0] frame_acc;
        logic [63:0] fps_acc;
        bit          on_p2;
        result_t     expected_q[$];
        int unsigned results_seen;
        int unsigned errors;

        function new();
            restart();
            results_seen = 0;
            errors = 0;
        endfunction

        function void restart();
            phase       = PH_MAG_G;
            err_seen    = 1'b0;
            err_kind    = KIND_EVENT;
            vacc        = '0;
            vgroups     = 0;
            run_left    = '0;
            ext_on      = 1'b0;
            platformer  = 1'b0;
            deaths_left = '0;
            p2_count    = '0;
            inputs_left = '0;
            frame_acc   = '0;
            fps_acc     = '0;
            on_p2       = 1'b0;
        endfunction

        function void enter(phase_t p);
            phase   = p;
            vacc    = '0;
            vgroups = 0;
            case (p)
                PH_DURATION:     run_left = DURATION_BYTES;
                PH_FPS: begin
                    run_left = FPS_BYTES;
                    fps_acc  = '0;
                end
                PH_SEED_COINS:   run_left = SEED_VARINTS;
                PH_FLAGS:        run_left = FLAG_BYTES;
                PH_BOTVER_LEVEL: run_left = BOTVER_VARINTS;
                default: ;
            endcase
        endfunction

        function void latch_error(logic [2:0] k);
            err_seen = 1'b1;
            err_kind = k;
        endfunction

        // zero length jumps straight to the next field
        function void length_field(logic [63:0] len, phase_t skip_p, phase_t next_p);
            if (len == 0) begin
                enter(next_p);
            end else begin
                enter(skip_p);
                run_left = len;
            end
        endfunction

        // move on to the next input record, switching to player two when due
        function void advance_input();
            if (inputs_left == 0 && !on_p2) begin
                on_p2       = 1'b1;
                inputs_left = p2_count;
                frame_acc   = '0;
            end
            enter(inputs_left == 0 ? PH_DONE : PH_INPUT);
        endfunction

        function void varint_done(logic [63:0] v);
            logic [63:0] delta;
            logic [1:0]  raw;
            result_t     r;
            case (phase)
                PH_VERSION: begin
                    if (v != FMT_VERSION) latch_error(KIND_VERSION);
                    else enter(PH_EXT_LEN);
                end
                PH_EXT_LEN: begin
                    ext_on = (v != 0);
                    length_field(v, PH_EXT_SKIP, PH_AUTH_LEN);
                end
                PH_AUTH_LEN:  length_field(v, PH_AUTH_SKIP, PH_DESC_LEN);
                PH_DESC_LEN:  length_field(v, PH_DESC_SKIP, PH_DURATION);
                PH_GAMEVER:   enter(PH_FPS);
                PH_SEED_COINS, PH_BOTVER_LEVEL: begin
                    run_left--;
                    if (run_left == 0)
                        enter(phase == PH_SEED_COINS ? PH_FLAGS : PH_LNAME_LEN);
                end
                PH_BOT_LEN:   length_field(v, PH_BOT_SKIP, PH_BOTVER_LEVEL);
                PH_LNAME_LEN: length_field(v, PH_LNAME_SKIP, PH_XDATA_LEN);
                PH_XDATA_LEN: length_field(v, PH_XDATA_SKIP, PH_DEATH_COUNT);
                PH_DEATH_COUNT: begin
                    deaths_left = v;
                    enter(v == 0 ? PH_TOTAL : PH_DEATHS);
                end
                PH_DEATHS: begin
                    deaths_left--;
                    if (deaths_left == 0) enter(PH_TOTAL);
                end
                PH_TOTAL: begin
                    p2_count = v;
                    enter(PH_P1COUNT);
                end
                PH_P1COUNT: begin
                    inputs_left = v;
                    p2_count    = (p2_count > v) ? p2_count - v : 64'd0;
                    on_p2       = 1'b0;
                    frame_acc   = '0;
                    advance_input();
                end
                PH_INPUT: begin
                    if (platformer) begin
                        delta = v >> 3;
                        raw   = v[2:1];
                    end else begin
                        delta = v >> 1;
                        raw   = RAW_DEFAULT;
                    end
                    frame_acc       = frame_acc + delta;
                    r               = '0;
                    r.kind          = KIND_EVENT;
                    r.frame         = frame_acc;
                    r.button        = (raw == RAW_LEFT)  ? BTN_LEFT :
                                      (raw == RAW_RIGHT) ? BTN_RIGHT : BTN_JUMP;
                    r.pressed       = v[0];
                    r.second_player = on_p2;
                    expected_q.insert(expected_q.size(), r);
                    inputs_left--;
                    if (ext_on) enter(PH_PHYS_LEN);
                    else advance_input();
                end
                PH_PHYS_LEN: begin
                    if (v == 0) begin
                        advance_input();
                    end else begin
                        enter(PH_PHYS_SKIP);
                        run_left = v;
                    end
                end
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            logic [63:0] v;
            int unsigned k;
            case (phase)
                PH_MAG_G: begin
                    if (b != MAGIC_G) latch_error(KIND_MAGIC);
                    else enter(PH_MAG_D);
                end
                PH_MAG_D: begin
                    if (b != MAGIC_D) latch_error(KIND_MAGIC);
                    else enter(PH_MAG_R);
                end
                PH_MAG_R: begin
                    if (b != MAGIC_R) latch_error(KIND_MAGIC);
                    else enter(PH_VERSION);
                end
                PH_EXT_SKIP, PH_AUTH_SKIP, PH_DESC_SKIP, PH_DURATION,
                PH_BOT_SKIP, PH_LNAME_SKIP, PH_XDATA_SKIP: begin
                    run_left--;
                    if (run_left == 0) enter(phase_t'(phase + 1));
                end
                PH_PHYS_SKIP: begin
                    run_left--;
                    if (run_left == 0) advance_input();
                end
                // fps word arrives least significant byte first
                PH_FPS: begin
                    k = int'(FPS_BYTES - run_left);
                    fps_acc[8*k +: 8] = b;
                    run_left--;
                    if (run_left == 0) enter(PH_SEED_COINS);
                end
                // second flag byte is the platformer flag
                PH_FLAGS: begin
                    if (run_left == 1) platformer = (b != 0);
                    run_left--;
                    if (run_left == 0) enter(PH_BOT_LEN);
                end
                PH_DONE: ;
                // every other phase reads a LEB128 varint
                default: begin
                    vacc = vacc | (64'(b[6:0]) << (7 * vgroups));
                    if (b[VARINT_CONT_BIT]) begin
                        vgroups++;
                        if (vgroups > VARINT_LAST_GRP) latch_error(KIND_LONG);
                    end else begin
                        v       = vacc;
                        vacc    = '0;
                        vgroups = 0;
                        varint_done(v);
                    end
                end
            endcase
        endfunction

        // called for each accepted s_ transaction
        function void note_byte(logic [7:0] b, logic eof);
            result_t r;
            if (!err_seen) take_byte(b);
            if (eof) begin
                r      = '0;
                r.last = 1'b1;
                if (err_seen) begin
                    r.kind = err_kind;
                end else if (phase == PH_DONE) begin
                    r.kind     = KIND_OK;
                    r.fps_bits = fps_acc;
                end else begin
                    r.kind = KIND_TRUNC;
                end
                expected_q.insert(expected_q.size(), r);
                restart();
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                          results_seen, name, got, want));
        endtask

        // called for each accepted m_ transaction
        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d (kind %0d) with nothing expected",
                                          results_seen, got.kind));
            end else begin
                want = expected_q.pop_front();
                compare_field("kind", got.kind, want.kind);
                compare_field("frame", got.frame, want.frame);
                compare_field("button", got.button, want.button);
                compare_field("pressed", got.pressed, want.pressed);
                compare_field("second_player", got.second_player, want.second_player);
                compare_field("fps_bits", got.fps_bits, want.fps_bits);
                compare_field("last", got.last, want.last);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        s_end_of_file = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_kind;
    logic [63:0] m_frame;
    logic [1:0]  m_button;
    logic        m_pressed;
    logic        m_second_player;
    logic [63:0] m_fps_bits;
    logic        m_last;

    replay_macro_stream_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_end_of_file   (s_end_of_file),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_frame         (m_frame),
        .m_button        (m_button),
        .m_pressed       (m_pressed),
        .m_second_player (m_second_player),
        .m_fps_bits      (m_fps_bits),
        .m_last          (m_last)
    );

    parse_scoreboard sb = new();

    logic [7:0]  file_q[$];
    flaw_t       flaw;
    int unsigned varint_idx;
    int unsigned len_idx;
    int unsigned long_at;
    int unsigned huge_at;
    int unsigned bytes_sent  = 0;
    int unsigned tx_calm     = 0;
    int unsigned rx_calm     = 0;
    bit          rx_hold_req = 1'b0;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // File generation
    // ------------------------------------------------------------------------
    // append one byte to the file under construction
    function automatic void add_byte(logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 127));
            1:       return 64'($urandom_range(0, 20000));
            2:       return {$urandom, $urandom};
            default: return 64'($urandom_range(0, 3));
        endcase
    endfunction

    // LEB128, sometimes padded with extra groups up to ten; the overlong flaw puts ten
    // continuation groups in place of one chosen varint
    function automatic void push_varint(logic [63:0] v);
        int unsigned need;
        int unsigned n;
        logic [7:0]  g;
        if (flaw == FLAW_LONG && varint_idx == long_at) begin
            repeat (10) add_byte(8'h80 | 8'($urandom_range(0, 127)));
        end else begin
            need = 1;
            while (need < 10 && (v >> (7 * need)) != 0) need++;
            n = need;
            if ($urandom_range(0, 7) == 0) n = $urandom_range(need, 10);
            for (int unsigned i = 0; i < n; i++) begin
                g = {1'b0, 7'(v >> (7 * i))};
                if (i == 9) g[6:1] = 6'($urandom);   // bits above 63, dropped
                g[7] = (i < n - 1);
                add_byte(g);
            end
        end
        varint_idx++;
    endfunction

    function automatic void push_blob(int unsigned n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    // length-prefixed block; the huge-skip flaw gives one block a length far
    // beyond the end of the file
    function automatic void push_len(int unsigned n);
        if (flaw == FLAW_HUGE_SKIP && len_idx == huge_at) begin
            push_varint({$urandom, $urandom} | 64'h1_0000_0000);
        end else begin
            push_varint(64'(n));
            push_blob(n);
        end
        len_idx++;
    endfunction

    function automatic logic [63:0] input_value(bit plat);
        logic [63:0] delta;
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        delta = 64'($urandom_range(0, 40));
        if (plat)
            return (delta << 3) | 64'($urandom_range(0, 3) << 1) | 64'($urandom_range(0, 1));
        return (delta << 1) | 64'($urandom_range(0, 1));
    endfunction

    // heavy: platformer, no extension, forty input records
    function automatic void build_file(flaw_t f, bit heavy);
        bit          ext;
        bit          plat;
        int unsigned pos;
        int unsigned ndeath;
        int unsigned p1n;
        int unsigned totaln;
        int unsigned p2n;
        logic [63:0] ver;
        file_q.delete();
        flaw       = f;
        varint_idx = 0;
        len_idx    = 0;
        long_at    = $urandom_range(0, 25);
        huge_at    = $urandom_range(0, 7);

        add_byte(MAGIC_G);
        add_byte(MAGIC_D);
        add_byte(MAGIC_R);
        if (f == FLAW_MAGIC) begin
            pos = $urandom_range(0, 2);
            file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
        end
        ver = FMT_VERSION;
        if (f == FLAW_VERSION) begin
            ver = $urandom_range(0, 1) ? 64'($urandom_range(0, 300)) : {$urandom, $urandom};
            if (ver == FMT_VERSION) ver = 64'd3;
        end
        push_varint(ver);

        // extension name, author, description
        ext = heavy ? 1'b0 : 1'($urandom_range(0, 1));
        push_len(ext ? $urandom_range(1, 3) : 0);
        push_len($urandom_range(0, 3));
        push_len($urandom_range(0, 3));
        push_blob(4);                       // duration
        push_varint(rand_value());          // game version
        push_blob(8);                       // fps word
        push_varint(rand_value());          // seed
        push_varint(rand_value());          // coins
        plat = heavy ? 1'b1 : 1'($urandom_range(0, 1));
        add_byte(8'($urandom));
        add_byte(plat ? 8'($urandom_range(1, 255)) : 8'h00);
        push_len($urandom_range(0, 3));     // bot name
        push_varint(rand_value());          // bot version
        push_varint(rand_value());          // level id
        push_len($urandom_range(0, 3));     // level name
        push_len($urandom_range(0, 3));     // extension data

        ndeath = $urandom_range(0, 3);
        push_varint(64'(ndeath));
        repeat (ndeath) push_varint(rand_value());

        // counts; now and then the total is at or below the player-one count
        p1n = heavy ? 20 : $urandom_range(0, 6);
        if (heavy) totaln = 40;
        else if ($urandom_range(0, 4) == 0) totaln = $urandom_range(0, p1n);
        else totaln = p1n + $urandom_range(0, 6);
        push_varint(64'(totaln));
        push_varint(64'(p1n));
        p2n = (totaln > p1n) ? totaln - p1n : 0;
        for (int unsigned i = 0; i < p1n + p2n; i++) begin
            push_varint(input_value(plat));
            if (ext) push_len($urandom_range(0, 3));
        end

        if (!heavy && $urandom_range(0, 3) == 0) push_blob($urandom_range(1, 3));
        if (f == FLAW_CUT && file_q.size() > 1) begin
            pos = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > pos) void'(file_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // idle cycles before the next transaction, with calm stretches of none
    function automatic int unsigned draw_idle(ref int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 40);
        return $urandom_range(0, 4);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eof);
        int unsigned gap;
        gap = draw_idle(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int unsigned i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Result receiver
    initial begin
        result_t     got;
        int unsigned gap;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req) begin
                // long hold-off so that the internal queue fills
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = draw_idle(rx_calm);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.kind          = m_kind;
            got.frame         = m_frame;
            got.button        = m_button;
            got.pressed       = m_pressed;
            got.second_player = m_second_player;
            got.fps_bits      = m_fps_bits;
            got.last          = m_last;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned k;
        flaw = FLAW_NONE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // short files: bad first byte, early end, bad version on the final
        // byte, ten continuation groups
        file_q = '{8'hFF};
        send_file();
        file_q = '{MAGIC_G, MAGIC_D};
        send_file();
        file_q = '{MAGIC_G, MAGIC_D, MAGIC_R, 8'h03};
        send_file();
        file_q = '{MAGIC_G, MAGIC_D, MAGIC_R};
        repeat (10) add_byte(8'hFF);
        send_file();
        hold_until_drained();

        // back-to-back file rich in events against a stalled receiver
        build_file(FLAW_NONE, 1'b1);
        tx_calm     = file_q.size();
        rx_hold_req = 1'b1;
        send_file();
        hold_until_drained();

        // random files, mostly well formed
        while (bytes_sent < ITEM_TARGET) begin
            k = $urandom_range(0, 13);
            build_file(k < 9 ? FLAW_NONE : flaw_t'(k - 8), 1'b0);
            send_file();
            if ($urandom_range(0, 4) == 0) hold_until_drained();
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
